FILE: sv/positional_list_engine_macros.svh
// assertion macros for the positional list engine
// used by modules that carry clk_i and rst_ni
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ple_pkg.sv
// shared types, codes and constants of the positional list engine
// no dependencies
`default_nettype none

package ple_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int MODE_W     = 3;
  localparam int POS_W      = 11;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int DATA_OUT_W = 32;
  localparam int COUNT_W    = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT   = 3'd0,
    MODE_APPEND   = 3'd1,
    MODE_LOCATE   = 3'd2,
    MODE_RETRIEVE = 3'd3,
    MODE_REMOVE   = 3'd4,
    MODE_CLEAR    = 3'd5,
    MODE_PREV     = 3'd6,
    MODE_NEXT     = 3'd7
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    RD_REQ = 1'b0,
    RD_IDX = 1'b1
  } rd_src_e;

  typedef enum logic [2:0] {
    IDX_HOLD     = 3'd0,
    IDX_LD_CNTM1 = 3'd1,
    IDX_LD_POS   = 3'd2,
    IDX_LD_ZERO  = 3'd3,
    IDX_INC      = 3'd4,
    IDX_DEC      = 3'd5
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_e;

  typedef struct packed {
    logic    accept;
    logic    chk;
    logic    rd_en;
    rd_src_e rd_src;
    idx_op_e idx_op;
    logic    sh_rd;
    logic    sh_up;
    logic    wr_new;
    cnt_op_e cnt_op;
    logic    data_cap;
    logic    found_cap;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  err;
    logic  slot_lt_cnt;
    logic  idx_at_slot;
    logic  idx_at_last;
    logic  pos_is_last;
    logic  cnt_zero;
    logic  idx_nz;
    logic  match;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/ple_if.sv
// request and response channel interfaces of the positional list engine
// depends on ple_pkg
`default_nettype none

interface ple_req_if;
  logic                         valid;
  logic                         ready;
  logic [ple_pkg::MODE_W-1:0]   mode;
  logic [ple_pkg::POS_W-1:0]    position;
  logic [ple_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface ple_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ple_pkg::STATUS_W-1:0]    status;
  logic [ple_pkg::DATA_OUT_W-1:0]  data_out;
  logic [ple_pkg::POS_W-1:0]       found_position;
  logic [ple_pkg::COUNT_W-1:0]     count;
  logic                            is_empty;

  modport source (output valid, output status, output data_out, output found_position,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input status, input data_out, input found_position,
                  input count, input is_empty, output ready);
endinterface

`default_nettype wire

FILE: sv/ple_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/ple_ctrl.sv
// controller state machine of the positional list engine
// depends on ple_pkg; drives the datapath through cmd_t, reads sts_t
`default_nettype none

module ple_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ple_pkg::sts_t sts_i,
  output ple_pkg::cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_CHECK    = 10'b00_0000_0010,
    S_RD_WAIT  = 10'b00_0000_0100,
    S_SHUP     = 10'b00_0000_1000,
    S_SHDN     = 10'b00_0001_0000,
    S_DRAIN    = 10'b00_0010_0000,
    S_WRNEW    = 10'b00_0100_0000,
    S_SCAN     = 10'b00_1000_0000,
    S_SCAN_END = 10'b01_0000_0000,
    S_RESP     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.chk = 1'b1;
        if (sts_i.err) begin
          state_d = S_RESP;
        end else begin
          unique case (sts_i.mode)
            ple_pkg::MODE_INSERT, ple_pkg::MODE_APPEND: begin
              if (sts_i.slot_lt_cnt) begin
                cmd_o.idx_op = ple_pkg::IDX_LD_CNTM1;
                state_d      = S_SHUP;
              end else begin
                state_d = S_WRNEW;
              end
            end
            ple_pkg::MODE_LOCATE: begin
              if (sts_i.cnt_zero) begin
                state_d = S_RESP;
              end else begin
                cmd_o.idx_op = ple_pkg::IDX_LD_ZERO;
                state_d      = S_SCAN;
              end
            end
            ple_pkg::MODE_CLEAR: begin
              cmd_o.cnt_op = ple_pkg::CNT_CLR;
              state_d      = S_RESP;
            end
            ple_pkg::MODE_REMOVE: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = ple_pkg::RD_REQ;
              cmd_o.idx_op = ple_pkg::IDX_LD_POS;
              state_d      = S_RD_WAIT;
            end
            ple_pkg::MODE_RETRIEVE, ple_pkg::MODE_PREV, ple_pkg::MODE_NEXT: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = ple_pkg::RD_REQ;
              state_d      = S_RD_WAIT;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_RD_WAIT: begin
        cmd_o.data_cap = 1'b1;
        if (sts_i.mode == ple_pkg::MODE_REMOVE) begin
          if (sts_i.pos_is_last) begin
            cmd_o.cnt_op = ple_pkg::CNT_DEC;
            state_d      = S_RESP;
          end else begin
            state_d = S_SHDN;
          end
        end else begin
          state_d = S_RESP;
        end
      end
      S_SHUP: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = ple_pkg::RD_IDX;
        cmd_o.sh_rd  = 1'b1;
        cmd_o.sh_up  = 1'b1;
        if (sts_i.idx_at_slot) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.idx_op = ple_pkg::IDX_DEC;
        end
      end
      S_SHDN: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = ple_pkg::RD_IDX;
        cmd_o.sh_rd  = 1'b1;
        if (sts_i.idx_at_last) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.idx_op = ple_pkg::IDX_INC;
        end
      end
      S_DRAIN: begin
        if (sts_i.mode == ple_pkg::MODE_REMOVE) begin
          cmd_o.cnt_op = ple_pkg::CNT_DEC;
          state_d      = S_RESP;
        end else begin
          state_d = S_WRNEW;
        end
      end
      S_WRNEW: begin
        cmd_o.wr_new = 1'b1;
        cmd_o.cnt_op = ple_pkg::CNT_INC;
        state_d      = S_RESP;
      end
      S_SCAN: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = ple_pkg::RD_IDX;
        if (sts_i.idx_nz && sts_i.match) begin
          cmd_o.found_cap = 1'b1;
          state_d         = S_RESP;
        end else if (sts_i.idx_at_last) begin
          state_d = S_SCAN_END;
        end else begin
          cmd_o.idx_op = ple_pkg::IDX_INC;
        end
      end
      S_SCAN_END: begin
        cmd_o.found_cap = sts_i.match;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/ple_dpath.sv
// datapath of the positional list engine: request, count, index, list ram, result
// depends on ple_pkg, ple_ram and positional_list_engine_macros.svh
`default_nettype none

`include "positional_list_engine_macros.svh"

module ple_dpath #(
  parameter int DEPTH      = ple_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire ple_pkg::cmd_t                      cmd_i,
  output ple_pkg::sts_t                           sts_o,
  input  wire logic [ple_pkg::MODE_W-1:0]         req_mode_i,
  input  wire logic [ple_pkg::POS_W-1:0]          req_position_i,
  input  wire logic [ple_pkg::VALUE_W-1:0]        req_value_i,
  input  wire logic                               rsp_ready_i,
  output logic                                    rsp_valid_o,
  output logic [ple_pkg::STATUS_W-1:0]            rsp_status_o,
  output logic [ple_pkg::DATA_OUT_W-1:0]          rsp_data_out_o,
  output logic [ple_pkg::POS_W-1:0]               rsp_found_position_o,
  output logic [ple_pkg::COUNT_W-1:0]             rsp_count_o,
  output logic                                    rsp_is_empty_o
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int KW  = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
  localparam int XW  = (DATA_WIDTH > ple_pkg::VALUE_W) ? DATA_WIDTH : ple_pkg::VALUE_W;
  localparam int OXW = (DATA_WIDTH > ple_pkg::DATA_OUT_W) ? DATA_WIDTH : ple_pkg::DATA_OUT_W;

  ple_pkg::mode_e          mode_q;
  logic [ple_pkg::POS_W-1:0] pos_q;
  logic [DATA_WIDTH-1:0]   word_q;
  logic [CW-1:0]           cnt_q;
  logic [AW-1:0]           idx_q;
  logic [AW-1:0]           last_raddr_q;
  logic                    sh_pend_q;
  logic [AW-1:0]           sh_waddr_q;
  ple_pkg::status_e        status_q;
  logic [DATA_WIDTH-1:0]   data_q;
  logic [ple_pkg::POS_W-1:0] found_q;

  logic                    rsp_valid_q;
  ple_pkg::status_e        rsp_status_q;
  logic [ple_pkg::DATA_OUT_W-1:0] rsp_data_q;
  logic [ple_pkg::POS_W-1:0] rsp_found_q;
  logic [ple_pkg::COUNT_W-1:0] rsp_count_q;
  logic                    rsp_empty_q;

  logic [XW-1:0]           val_x;
  logic [OXW-1:0]          data_x;
  logic [KW-1:0]           pos_x, cnt_x, slot_x, idx_x, raddr_x, found_x;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           waddr;
  logic [DATA_WIDTH-1:0]   wdata;
  logic                    we;
  logic [DATA_WIDTH-1:0]   rd_word;
  ple_pkg::status_e        chk_status;
  logic                    out_free;

  assign val_x   = XW'(req_value_i);
  assign pos_x   = KW'(pos_q);
  assign cnt_x   = KW'(cnt_q);
  assign idx_x   = KW'(idx_q);
  assign slot_x  = (mode_q == ple_pkg::MODE_APPEND) ? cnt_x : (pos_x - KW'(1));
  assign found_x = KW'(last_raddr_q) + KW'(1);
  assign data_x  = OXW'(data_q);
  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    unique case (mode_q)
      ple_pkg::MODE_PREV: raddr_x = pos_x - KW'(2);
      ple_pkg::MODE_NEXT: raddr_x = pos_x;
      default:            raddr_x = pos_x - KW'(1);
    endcase
  end

  assign raddr = (cmd_i.rd_src == ple_pkg::RD_IDX) ? idx_q : raddr_x[AW-1:0];

  always_comb begin
    unique case (mode_q)
      ple_pkg::MODE_INSERT: begin
        if (pos_x == '0 || pos_x > cnt_x + KW'(1)) begin
          chk_status = ple_pkg::ST_BADPOS;
        end else if (cnt_x >= KW'(DEPTH)) begin
          chk_status = ple_pkg::ST_FULL;
        end else begin
          chk_status = ple_pkg::ST_OK;
        end
      end
      ple_pkg::MODE_APPEND: begin
        chk_status = (cnt_x >= KW'(DEPTH)) ? ple_pkg::ST_FULL : ple_pkg::ST_OK;
      end
      ple_pkg::MODE_LOCATE: chk_status = ple_pkg::ST_NOTFOUND;
      ple_pkg::MODE_RETRIEVE, ple_pkg::MODE_REMOVE: begin
        chk_status = (pos_x == '0 || pos_x > cnt_x) ? ple_pkg::ST_BADPOS : ple_pkg::ST_OK;
      end
      ple_pkg::MODE_CLEAR: chk_status = ple_pkg::ST_OK;
      ple_pkg::MODE_PREV: begin
        chk_status = (pos_x < KW'(2) || pos_x > cnt_x) ? ple_pkg::ST_BADPOS : ple_pkg::ST_OK;
      end
      ple_pkg::MODE_NEXT: begin
        chk_status = (pos_x == '0 || pos_x >= cnt_x) ? ple_pkg::ST_BADPOS : ple_pkg::ST_OK;
      end
      default: chk_status = ple_pkg::ST_OK;
    endcase
  end

  always_comb begin
    sts_o             = '0;
    sts_o.mode        = mode_q;
    sts_o.err         = (chk_status == ple_pkg::ST_BADPOS) || (chk_status == ple_pkg::ST_FULL);
    sts_o.slot_lt_cnt = slot_x < cnt_x;
    sts_o.idx_at_slot = idx_x == slot_x;
    sts_o.idx_at_last = idx_x == (cnt_x - KW'(1));
    sts_o.pos_is_last = pos_x == cnt_x;
    sts_o.cnt_zero    = cnt_q == '0;
    sts_o.idx_nz      = idx_q != '0;
    sts_o.match       = rd_word == word_q;
    sts_o.out_free    = out_free;
  end

  // shift writes take the word read in the previous cycle
  assign we    = sh_pend_q || cmd_i.wr_new;
  assign waddr = sh_pend_q ? sh_waddr_q : slot_x[AW-1:0];
  assign wdata = sh_pend_q ? rd_word : word_q;

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sh_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      sh_pend_q <= cmd_i.sh_rd;
      unique case (cmd_i.cnt_op)
        ple_pkg::CNT_INC:  cnt_q <= cnt_q + CW'(1);
        ple_pkg::CNT_DEC:  cnt_q <= cnt_q - CW'(1);
        ple_pkg::CNT_CLR:  cnt_q <= '0;
        default:           cnt_q <= cnt_q;
      endcase
      if (cmd_i.res_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= ple_pkg::mode_e'(req_mode_i);
      pos_q   <= req_position_i;
      word_q  <= val_x[DATA_WIDTH-1:0];
      data_q  <= '0;
      found_q <= '0;
    end
    if (cmd_i.chk) begin
      status_q <= chk_status;
    end
    if (cmd_i.data_cap) begin
      data_q <= rd_word;
    end
    if (cmd_i.found_cap) begin
      found_q  <= found_x[ple_pkg::POS_W-1:0];
      status_q <= ple_pkg::ST_OK;
    end
    if (cmd_i.rd_en) begin
      last_raddr_q <= raddr;
    end
    if (cmd_i.sh_rd) begin
      sh_waddr_q <= cmd_i.sh_up ? (idx_q + AW'(1)) : (idx_q - AW'(1));
    end
    unique case (cmd_i.idx_op)
      ple_pkg::IDX_LD_CNTM1: idx_q <= AW'(cnt_x - KW'(1));
      ple_pkg::IDX_LD_POS:   idx_q <= pos_x[AW-1:0];
      ple_pkg::IDX_LD_ZERO:  idx_q <= '0;
      ple_pkg::IDX_INC:      idx_q <= idx_q + AW'(1);
      ple_pkg::IDX_DEC:      idx_q <= idx_q - AW'(1);
      default:               idx_q <= idx_q;
    endcase
    if (cmd_i.res_load) begin
      rsp_status_q <= status_q;
      rsp_data_q   <= data_x[ple_pkg::DATA_OUT_W-1:0];
      rsp_found_q  <= found_q;
      rsp_count_q  <= cnt_x[ple_pkg::COUNT_W-1:0];
      rsp_empty_q  <= cnt_q == '0;
    end
  end

  assign rsp_valid_o          = rsp_valid_q;
  assign rsp_status_o         = rsp_status_q;
  assign rsp_data_out_o       = rsp_data_q;
  assign rsp_found_position_o = rsp_found_q;
  assign rsp_count_o          = rsp_count_q;
  assign rsp_is_empty_o       = rsp_empty_q;

  `PLE_ASSERT_NOW(a_wr_port_excl, sh_pend_q, !cmd_i.wr_new, "shift write collides with new word")
  `PLE_ASSERT_NOW(a_res_no_drop, cmd_i.res_load, !rsp_valid_q || rsp_ready_i, "result overwritten")
  `PLE_ASSERT_NOW(a_inc_not_full, cmd_i.cnt_op == ple_pkg::CNT_INC, cnt_q < CW'(DEPTH),
                  "count grows past depth")
  `PLE_ASSERT_NOW(a_dec_not_empty, cmd_i.cnt_op == ple_pkg::CNT_DEC, cnt_q != '0,
                  "count drops below zero")
  `PLE_ASSERT_NEXT(a_shift_drains, cmd_i.sh_rd, !cmd_i.accept, "word taken with shift pending")

endmodule

`default_nettype wire

FILE: sv/positional_list_engine.sv
// top level of the positional list engine: controller, datapath and channel wiring
// depends on ple_pkg, ple_if, ple_ctrl and ple_dpath
//
// channel  role   fields
// req_i    sink   mode, position, value
// rsp_o    source status, data_out, found_position, count, is_empty
//
// retrieve, previous, next: one ram read; clear, errors, locate on an empty list: none
// insert, append: one entry moved per cycle from the slot up, then the new word is written
// remove: the word is read, then later entries move down, none for the last entry
// locate: entries are scanned from the first until a match or the end of the list
// reset clears the entry count, pending shift and result valid; the list ram is not swept
// a result waits in the output register; a full unread register holds the next result back
`default_nettype none

module positional_list_engine #(
  parameter int DEPTH      = ple_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  ple_req_if.sink   req_i,
  ple_rsp_if.source rsp_o
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;
  logic          in_ready;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ple_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .req_mode_i           (req_i.mode),
    .req_position_i       (req_i.position),
    .req_value_i          (req_i.value),
    .rsp_ready_i          (rsp_o.ready),
    .rsp_valid_o          (rsp_o.valid),
    .rsp_status_o         (rsp_o.status),
    .rsp_data_out_o       (rsp_o.data_out),
    .rsp_found_position_o (rsp_o.found_position),
    .rsp_count_o          (rsp_o.count),
    .rsp_is_empty_o       (rsp_o.is_empty)
  );

  assign req_i.ready = in_ready;

endmodule

`default_nettype wire

FILE: dv/tb_positional_list_engine.sv
// self-checking testbench for positional_list_engine: a directed table and random words
// under several idle and stall mixes, each response from the table or a shadow list
// depends on ple_pkg, ple_if and the positional_list_engine rtl
`timescale 1ns / 1ps

module tb_positional_list_engine;

  localparam int LIST_DEPTH       = ple_pkg::DEPTH_DEF;
  localparam int RANDOM_PER_PHASE = 139;
  localparam int DRAIN_CYCLES     = 1100;

  typedef logic [ple_pkg::POS_W-1:0]      pos_t;
  typedef logic [ple_pkg::COUNT_W-1:0]    count_t;
  typedef logic [ple_pkg::VALUE_W-1:0]    value_t;
  typedef logic [ple_pkg::DATA_OUT_W-1:0] data_t;

  typedef struct packed {
    ple_pkg::status_e status;
    data_t            data;
    pos_t             found;
    count_t           count;
    logic             empty;
  } response_t;

  typedef struct packed {
    ple_pkg::mode_e mode;
    pos_t           position;
    value_t         value;
    logic           typed;
    response_t      want;
  } vector_t;

  localparam response_t PREDICTED    = '0;
  localparam response_t BAD_ON_EMPTY = '{ple_pkg::ST_BADPOS, 32'd0, 11'd0, 11'd0, 1'b1};
  localparam response_t BAD_AT_FOUR  = '{ple_pkg::ST_BADPOS, 32'd0, 11'd0, 11'd4, 1'b0};

  vector_t directed_rows [25] = '{
    '{ple_pkg::MODE_RETRIEVE, 11'd1,    32'h0000_0000, 1'b1, BAD_ON_EMPTY},
    '{ple_pkg::MODE_REMOVE,   11'd0,    32'h0000_0000, 1'b1, BAD_ON_EMPTY},
    '{ple_pkg::MODE_PREV,     11'd1,    32'h0000_0000, 1'b1, BAD_ON_EMPTY},
    '{ple_pkg::MODE_NEXT,     11'd0,    32'h0000_0000, 1'b1, BAD_ON_EMPTY},
    '{ple_pkg::MODE_LOCATE,   11'd0,    32'h0000_0000, 1'b1,
      '{ple_pkg::ST_NOTFOUND, 32'd0, 11'd0, 11'd0, 1'b1}},
    '{ple_pkg::MODE_INSERT,   11'd0,    32'h0000_0005, 1'b1, BAD_ON_EMPTY},
    '{ple_pkg::MODE_INSERT,   11'd2,    32'h0000_0005, 1'b1, BAD_ON_EMPTY},
    '{ple_pkg::MODE_INSERT,   11'd1,    32'hFFFF_FFFF, 1'b1,
      '{ple_pkg::ST_OK, 32'd0, 11'd0, 11'd1, 1'b0}},
    '{ple_pkg::MODE_APPEND,   11'd2047, 32'h0000_0000, 1'b1,
      '{ple_pkg::ST_OK, 32'd0, 11'd0, 11'd2, 1'b0}},
    '{ple_pkg::MODE_INSERT,   11'd2,    32'hA5A5_5A5A, 1'b0, PREDICTED},
    '{ple_pkg::MODE_APPEND,   11'd0,    32'h0000_0001, 1'b0, PREDICTED},
    '{ple_pkg::MODE_RETRIEVE, 11'd1,    32'h0000_0000, 1'b1,
      '{ple_pkg::ST_OK, 32'hFFFF_FFFF, 11'd0, 11'd4, 1'b0}},
    '{ple_pkg::MODE_LOCATE,   11'd0,    32'h0000_0000, 1'b0, PREDICTED},
    '{ple_pkg::MODE_LOCATE,   11'd0,    32'h0000_1234, 1'b1,
      '{ple_pkg::ST_NOTFOUND, 32'd0, 11'd0, 11'd4, 1'b0}},
    '{ple_pkg::MODE_NEXT,     11'd4,    32'h0000_0000, 1'b1, BAD_AT_FOUR},
    '{ple_pkg::MODE_NEXT,     11'd1,    32'h0000_0000, 1'b0, PREDICTED},
    '{ple_pkg::MODE_PREV,     11'd1,    32'h0000_0000, 1'b1, BAD_AT_FOUR},
    '{ple_pkg::MODE_PREV,     11'd4,    32'h0000_0000, 1'b0, PREDICTED},
    '{ple_pkg::MODE_RETRIEVE, 11'd5,    32'h0000_0000, 1'b1, BAD_AT_FOUR},
    '{ple_pkg::MODE_RETRIEVE, 11'd2047, 32'h0000_0000, 1'b1, BAD_AT_FOUR},
    '{ple_pkg::MODE_REMOVE,   11'd5,    32'h0000_0000, 1'b1, BAD_AT_FOUR},
    '{ple_pkg::MODE_REMOVE,   11'd2,    32'h0000_0000, 1'b0, PREDICTED},
    '{ple_pkg::MODE_REMOVE,   11'd3,    32'h0000_0000, 1'b0, PREDICTED},
    '{ple_pkg::MODE_CLEAR,    11'd2047, 32'hFFFF_FFFF, 1'b1,
      '{ple_pkg::ST_OK, 32'd0, 11'd0, 11'd0, 1'b1}},
    '{ple_pkg::MODE_APPEND,   11'd0,    32'h8000_0000, 1'b1,
      '{ple_pkg::ST_OK, 32'd0, 11'd0, 11'd1, 1'b0}}
  };

  logic clk_i;
  logic rst_ni;

  ple_req_if req_if ();
  ple_rsp_if rsp_if ();

  positional_list_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  value_t      shadow_list [LIST_DEPTH];
  int unsigned shadow_count;
  response_t   pending_results [$];
  value_t      value_pool [8];
  int          mismatch_count;
  int          req_idle_pct;
  int          rsp_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic ple_pkg::status_e shadow_insert(int unsigned slot_pos, value_t v);
    if (slot_pos < 1 || slot_pos > shadow_count + 1) return ple_pkg::ST_BADPOS;
    if (shadow_count >= LIST_DEPTH) return ple_pkg::ST_FULL;
    for (int unsigned k = shadow_count; k > slot_pos - 1; k--) shadow_list[k] = shadow_list[k - 1];
    shadow_list[slot_pos - 1] = v;
    shadow_count++;
    return ple_pkg::ST_OK;
  endfunction

  function automatic response_t apply_request(ple_pkg::mode_e m, pos_t p, value_t v);
    response_t   r;
    int unsigned pos;
    r = '0;
    r.status = ple_pkg::ST_OK;
    pos = 32'(p);
    case (m)
      ple_pkg::MODE_INSERT: r.status = shadow_insert(pos, v);
      ple_pkg::MODE_APPEND: r.status = shadow_insert(shadow_count + 1, v);
      ple_pkg::MODE_LOCATE: begin
        r.status = ple_pkg::ST_NOTFOUND;
        for (int unsigned k = 0; k < shadow_count; k++) begin
          if (r.status == ple_pkg::ST_NOTFOUND && shadow_list[k] == v) begin
            r.status = ple_pkg::ST_OK;
            r.found  = pos_t'(k + 1);
          end
        end
      end
      ple_pkg::MODE_RETRIEVE: begin
        if (pos < 1 || pos > shadow_count) r.status = ple_pkg::ST_BADPOS;
        else r.data = shadow_list[pos - 1];
      end
      ple_pkg::MODE_REMOVE: begin
        if (pos < 1 || pos > shadow_count) begin
          r.status = ple_pkg::ST_BADPOS;
        end else begin
          r.data = shadow_list[pos - 1];
          for (int unsigned k = pos - 1; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k + 1];
          shadow_count--;
        end
      end
      ple_pkg::MODE_CLEAR: shadow_count = 0;
      ple_pkg::MODE_PREV: begin
        if (pos < 2 || pos > shadow_count) r.status = ple_pkg::ST_BADPOS;
        else r.data = shadow_list[pos - 2];
      end
      default: begin
        if (pos < 1 || pos >= shadow_count) r.status = ple_pkg::ST_BADPOS;
        else r.data = shadow_list[pos];
      end
    endcase
    r.count = count_t'(shadow_count);
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] %s: got %h want %h", $time, what, got, want);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // one word on the request channel, prediction taken at the accepting edge
  task automatic send_word(ple_pkg::mode_e m, pos_t p, value_t v,
                           logic typed = 1'b0, response_t want = PREDICTED);
    response_t r;
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= m;
    req_if.position <= p;
    req_if.value    <= v;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    r = apply_request(m, p, v);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic pick_request(output ple_pkg::mode_e m, output pos_t p, output value_t v);
    int unsigned roll;
    int unsigned remove_bias;
    remove_bias = (shadow_count > 40) ? 30 : 0;
    roll = $urandom_range(99 + remove_bias);
    if (roll < 20) m = ple_pkg::MODE_INSERT;
    else if (roll < 32) m = ple_pkg::MODE_APPEND;
    else if (roll < 47) m = ple_pkg::MODE_LOCATE;
    else if (roll < 60) m = ple_pkg::MODE_RETRIEVE;
    else if (roll < 62) m = ple_pkg::MODE_CLEAR;
    else if (roll < 72) m = ple_pkg::MODE_PREV;
    else if (roll < 82) m = ple_pkg::MODE_NEXT;
    else m = ple_pkg::MODE_REMOVE;
    case ($urandom_range(9))
      8: begin
        case ($urandom_range(3))
          0: p = '0;
          1: p = 11'd1;
          2: p = pos_t'(shadow_count);
          default: p = pos_t'(shadow_count + 1);
        endcase
      end
      9: p = pos_t'($urandom_range(2047));
      default: p = pos_t'($urandom_range(shadow_count + 1));
    endcase
    v = $urandom_range(1) ? value_pool[$urandom_range(7)] : $urandom;
  endtask

  task automatic run_random(int n);
    ple_pkg::mode_e m;
    pos_t           p;
    value_t         v;
    repeat (n) begin
      pick_request(m, p, v);
      send_word(m, p, v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk_i) begin : rsp_monitor
    response_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response word with nothing pending", 32'(rsp_if.status), 32'd0);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(rsp_if.status), 32'(want.status));
        check_field("data_out", rsp_if.data_out, want.data);
        check_field("found_position", 32'(rsp_if.found_position), 32'(want.found));
        check_field("count", 32'(rsp_if.count), 32'(want.count));
        check_field("is_empty", 32'(rsp_if.is_empty), 32'(want.empty));
      end
    end
  end

  initial begin
    mismatch_count = 0;
    req_idle_pct   = 0;
    rsp_stall_pct  = 0;
    shadow_count   = 0;
    value_pool[0]  = '0;
    value_pool[1]  = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom;
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.mode     <= ple_pkg::MODE_INSERT;
    req_if.position <= '0;
    req_if.value    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].mode, directed_rows[i].position, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].want);
    hold_until_drained();

    run_random(RANDOM_PER_PHASE);
    hold_until_drained();

    req_idle_pct = 57;
    run_random(RANDOM_PER_PHASE);
    hold_until_drained();

    req_idle_pct  = 0;
    rsp_stall_pct = 57;
    run_random(RANDOM_PER_PHASE);
    hold_until_drained();

    req_idle_pct  = 38;
    rsp_stall_pct = 38;
    run_random(RANDOM_PER_PHASE);
    hold_until_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/ple_pkg.sv
sv/ple_if.sv
sv/ple_ram.sv
sv/ple_ctrl.sv
sv/ple_dpath.sv
sv/positional_list_engine.sv
dv/tb_positional_list_engine.sv
